@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// ARC_ASSERT checks a property at every clock edge outside reset.
// ARC_ASSERT_RST checks a property at every clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ARC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ARC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed during reset");
`else
`define ARC_ASSERT(lbl, prop)
`define ARC_ASSERT_RST(lbl, prop)
`endif

`endif

@@ rtl/core/arc_pkg.sv @@
`timescale 1ns / 1ps

package arc_pkg;

  // Table geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  // Field widths
  localparam int unsigned AddrW  = 32;
  localparam int unsigned MacW   = 48;
  localparam int unsigned TimeW  = 32;

  localparam logic [TimeW-1:0] TimeoutReset = TimeW'(60000);

  // Operation codes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_UPDATE = 2'd2
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [AddrW-1:0] ip_addr;
    logic [MacW-1:0]  mac_in;
  } arc_in_t;

  typedef struct packed {
    logic            hit;
    logic [MacW-1:0] mac_out;
  } arc_out_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [MacW-1:0]  mac;
    logic [TimeW-1:0] stamp;
  } arc_entry_t;

endpackage

@@ rtl/core/address_resolution_cache_unit.sv @@
`timescale 1ns / 1ps

// Address resolution cache: maps IPv4 addresses to MAC addresses in a table
// of arc_pkg::ENTRIES slots held in a RAM with a write port and a registered
// read port, each slot stamped with the tick count at its last write. One
// input beat is taken at a time. A tick, the unused code 3 or an update of
// address zero needs no scan; a lookup of address zero goes straight to the
// result stage. A lookup or update of any other address scans the RAM one
// slot per cycle until a slot ends the scan, and a lookup then loads its
// result beat into the output register. The scan rate is set by the one RAM
// read per cycle. A lookup result beat only goes out once the output register
// is free. Per-slot valid flops clear at reset, so no clearing pass is
// needed. The user must write the timeout register only while the block is
// idle, via cfg_we_i/cfg_data_i; the block does not enforce this. A slot is
// live when (now - stamp) mod 2^32 is below the timeout.

`include "assert_macros.svh"

module address_resolution_cache_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  arc_pkg::arc_in_t                  in_data_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output arc_pkg::arc_out_t                 out_data_o,
  // timeout register
  input  logic                              cfg_we_i,
  input  logic [arc_pkg::TimeW-1:0]         cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e                         state_q, state_d;
  logic [arc_pkg::IdxW-1:0]       chk_q, chk_d;
  logic [arc_pkg::TimeW-1:0]      now_q, now_d;
  logic [arc_pkg::TimeW-1:0]      timeout_q, timeout_d;
  logic                           out_valid_q, out_valid_d;
  arc_pkg::arc_out_t              out_data_q, out_data_d;
  arc_pkg::arc_in_t               req_q, req_d;
  arc_pkg::arc_out_t              res_q, res_d;

  // slot RAM and valid flops
  arc_pkg::arc_entry_t            mem_q [arc_pkg::ENTRIES];
  logic [arc_pkg::ENTRIES-1:0]    vld_q;
  arc_pkg::arc_entry_t            rd_data_q;
  logic                           rd_vld_q;
  logic [arc_pkg::IdxW-1:0]       rd_idx;
  logic                           wr_en;

  logic                           in_fire;
  logic                           is_last;
  logic [arc_pkg::TimeW-1:0]      age;
  logic                           addr_eq;
  logic                           live;
  logic                           slot_ok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // slot checks on the entry read in the previous cycle
  assign is_last = (chk_q == arc_pkg::LastIdx);
  assign age     = now_q - rd_data_q.stamp;
  assign addr_eq = rd_vld_q && (rd_data_q.addr == req_q.ip_addr);
  assign live    = addr_eq && (age < timeout_q);
  assign slot_ok = !rd_vld_q || addr_eq;

  // next-state logic
  always_comb begin
    state_d     = state_q;
    chk_d       = chk_q;
    now_d       = now_q;
    timeout_d   = timeout_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    req_d       = req_q;
    res_d       = res_q;
    rd_idx      = '0;
    wr_en       = 1'b0;

    if (cfg_we_i) begin
      timeout_d = cfg_data_i;
    end
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          req_d = in_data_i;
          chk_d = '0;
          case (in_data_i.func)
            arc_pkg::FUNC_TICK: begin
              now_d = now_q + arc_pkg::TimeW'(1);
            end
            arc_pkg::FUNC_LOOKUP: begin
              if (in_data_i.ip_addr == '0) begin
                res_d   = '0;
                state_d = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            arc_pkg::FUNC_UPDATE: begin
              if (in_data_i.ip_addr != '0) begin
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // prefetch the next slot while checking the current one
        rd_idx = is_last ? '0 : chk_q + arc_pkg::IdxW'(1);
        chk_d  = rd_idx;
        if (req_q.func == arc_pkg::FUNC_LOOKUP) begin
          if (live) begin
            res_d.hit     = 1'b1;
            res_d.mac_out = rd_data_q.mac;
            state_d       = ST_RESP;
          end else if (is_last) begin
            res_d   = '0;
            state_d = ST_RESP;
          end
        end else begin
          if (slot_ok) begin
            wr_en   = 1'b1;
            chk_d   = chk_q;
            state_d = ST_IDLE;
          end else if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_q       <= '0;
      now_q       <= '0;
      timeout_q   <= arc_pkg::TimeoutReset;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      now_q       <= now_d;
      timeout_q   <= timeout_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // request and result holding registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  // slot RAM: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[chk_q] <= '{addr: req_q.ip_addr, mac: req_q.mac_in, stamp: now_q};
    end
    rd_data_q <= mem_q[rd_idx];
  end

  // valid flops; an invalid slot reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[chk_q] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_idx];
    end
  end

  // assertions
  `ARC_ASSERT(a_wr_only_update,
              wr_en |-> (state_q == ST_SCAN) && (req_q.func == arc_pkg::FUNC_UPDATE))
  `ARC_ASSERT(a_wr_nonzero_addr, wr_en |-> (req_q.ip_addr != '0))
  `ARC_ASSERT(a_resp_from_lookup,
              (state_q == ST_RESP) |-> (req_q.func == arc_pkg::FUNC_LOOKUP))
  `ARC_ASSERT(a_tick_advances,
              (in_fire && (in_data_i.func == arc_pkg::FUNC_TICK))
              |=> (now_q == $past(now_q) + arc_pkg::TimeW'(1)))
  `ARC_ASSERT_RST(a_reset_no_beat, !rst_ni |=> !out_valid_o)

endmodule
